[hw/rtl/slt_pkg.sv]
package slt_pkg;

    localparam logic [1:0] KIND_CHECK  = 2'd0;
    localparam logic [1:0] KIND_LOCK   = 2'd1;
    localparam logic [1:0] KIND_UNLOCK = 2'd2;

    localparam int RSP_COUNT_W = 9;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] file_key;
        logic [7:0]  sentence_index;
        logic [15:0] user_key;
    } req_t;

    typedef struct packed {
        logic                   held_by_other;
        logic                   granted;
        logic                   table_full;
        logic [RSP_COUNT_W-1:0] entries_used;
    } rsp_t;

    typedef struct packed {
        logic [31:0] file_key;
        logic [7:0]  sentence_index;
        logic [15:0] user_key;
    } entry_t;

    typedef struct packed {
        logic load_req;
        logic clr_idx;
        logic inc_idx;
        logic rd_scan;
        logic rd_next;
        logic wr_shift;
        logic append;
        logic dec_cnt;
        logic set_res;
        logic res_held;
        logic res_granted;
        logic res_full;
        logic load_out;
    } slt_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       idx_lt_cnt;
        logic       next_lt_cnt;
        logic       place_hit;
        logic       full_hit;
        logic       user_same;
        logic       tbl_full;
    } slt_stat_t;

endpackage

[hw/rtl/slt_datapath.sv]
module slt_datapath #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  slt_pkg::req_t      req,
    input  slt_pkg::slt_cmd_t  cmd,
    output slt_pkg::slt_stat_t stat,
    output slt_pkg::rsp_t      rsp
);
    import slt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    entry_t        mem [TABLE_DEPTH];
    entry_t        rdata_reg;
    req_t          req_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          held_reg, granted_reg, full_reg;
    rsp_t          rsp_reg;
    logic [CW-1:0] idx_plus;
    logic          wr_en;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata;
    entry_t        key;

    assign key.file_key       = req_reg.file_key;
    assign key.sentence_index = req_reg.sentence_index;
    assign key.user_key       = req_reg.user_key;

    assign idx_plus = idx_reg + CW'(1);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.clr_idx)
        begin
            idx_next = '0;
        end
        else if (cmd.inc_idx)
        begin
            idx_next = idx_plus;
        end
        cnt_next = cnt_reg;
        if (cmd.append)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.dec_cnt)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_comb
    begin
        wr_en = cmd.wr_shift | cmd.append;
        waddr = cmd.append ? cnt_reg[AW-1:0] : idx_reg[AW-1:0];
        wdata = cmd.append ? key : rdata_reg;
        raddr = cmd.rd_next ? idx_plus[AW-1:0] : idx_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_scan | cmd.rd_next)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.set_res)
        begin
            held_reg    <= cmd.res_held;
            granted_reg <= cmd.res_granted;
            full_reg    <= cmd.res_full;
        end
        if (cmd.load_out)
        begin
            rsp_reg.held_by_other <= held_reg;
            rsp_reg.granted       <= granted_reg;
            rsp_reg.table_full    <= full_reg;
            rsp_reg.entries_used  <= RSP_COUNT_W'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        stat.kind        = req_reg.kind;
        stat.idx_lt_cnt  = idx_reg < cnt_reg;
        stat.next_lt_cnt = idx_plus < cnt_reg;
        stat.place_hit   = (rdata_reg.file_key == key.file_key) &&
                           (rdata_reg.sentence_index == key.sentence_index);
        stat.user_same   = rdata_reg.user_key == key.user_key;
        stat.full_hit    = stat.place_hit && stat.user_same;
        stat.tbl_full    = cnt_reg == CW'(TABLE_DEPTH);
    end

    assign rsp = rsp_reg;

endmodule

[hw/rtl/slt_ctrl.sv]
module slt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  slt_pkg::slt_stat_t stat,
    output slt_pkg::slt_cmd_t  cmd
);
    import slt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       known_kind;
    logic       hit;

    assign known_kind = (stat.kind == KIND_CHECK) || (stat.kind == KIND_LOCK) ||
                        (stat.kind == KIND_UNLOCK);
    assign hit = (stat.kind == KIND_UNLOCK) ? stat.full_hit : stat.place_hit;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.clr_idx  = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!known_kind)
                begin
                    cmd.set_res = 1'b1;
                    state_next  = S_DONE;
                end
                else if (stat.idx_lt_cnt)
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_CMP;
                end
                else
                begin
                    cmd.set_res = 1'b1;
                    if (stat.kind == KIND_LOCK)
                    begin
                        if (stat.tbl_full)
                        begin
                            cmd.res_full = 1'b1;
                        end
                        else
                        begin
                            cmd.append      = 1'b1;
                            cmd.res_granted = 1'b1;
                        end
                    end
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                if (!hit)
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = S_SCAN;
                end
                else if (stat.kind == KIND_UNLOCK)
                begin
                    state_next = S_SHRD;
                end
                else
                begin
                    cmd.set_res     = 1'b1;
                    cmd.res_held    = !stat.user_same;
                    cmd.res_granted = stat.user_same && (stat.kind == KIND_LOCK);
                    state_next      = S_DONE;
                end
            end
            S_SHRD:
            begin
                if (stat.next_lt_cnt)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHWR;
                end
                else
                begin
                    cmd.dec_cnt     = 1'b1;
                    cmd.set_res     = 1'b1;
                    cmd.res_granted = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_SHWR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.inc_idx  = 1'b1;
                state_next   = S_SHRD;
            end
            S_DONE:
            begin
                if (!valid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load_out)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = valid_reg;

endmodule

[hw/rtl/sentence_lock_table.sv]
// Sentence lock table: each item is a check, lock or unlock of one (file, sentence) place,
// and each item yields exactly one result item (for any other kind, with no flag set).
// Entries live in a single-port memory that is searched from the oldest entry up; each
// entry examined takes a read state and a compare state, as the read data is registered.
// The entries examined are all of them when no entry matches. An unlock also moves every
// later entry down one place, reading each moved entry and writing it one place lower.
// One item is in work at a time; a finished result waits in an output register, and the
// next item is taken as soon as its result has moved there.
module sentence_lock_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  slt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output slt_pkg::rsp_t rsp
);
    import slt_pkg::*;

    slt_cmd_t  cmd;
    slt_stat_t stat;

    slt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    slt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $countones({rsp.held_by_other, rsp.granted, rsp.table_full}) <= 1)
        else $error("more than one outcome flag set in a result item");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("a new item was not held off while the previous one was in work");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("a result item appeared without an item in work");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import slt_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [31:0] FILL_FILE = 32'h5000_0000;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    sentence_lock_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    req_t pending_req[$];
    rsp_t expected_rsp[$];
    entry_t held_locks[$];

    int errors = 0;
    int items_queued = 0;
    int requests_done = 0;
    int results_checked = 0;
    int grants = 0;
    int refused_owner = 0;
    int refused_full = 0;
    int peak_entries = 0;
    int cycle_count = 0;

    int burst_left;
    int gap_left;
    int stall_mode;
    int mode_left;
    int hold_left;
    int next_hold_at;

    logic [31:0] file_pool[4];
    logic [7:0] sent_pool[6];
    logic [15:0] user_pool[3];
    logic [15:0] fill_user[TABLE_DEPTH];

    function automatic rsp_t lookup_lock(req_t r);
        rsp_t res;
        entry_t e;
        int hit;
        res = '0;
        hit = -1;
        e = {r.file_key, r.sentence_index, r.user_key};
        case (r.kind)
            KIND_CHECK, KIND_LOCK:
            begin
                for (int i = 0; i < held_locks.size() && hit < 0; i++)
                begin
                    if (held_locks[i].file_key == r.file_key &&
                        held_locks[i].sentence_index == r.sentence_index)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    if (held_locks[hit].user_key != r.user_key)
                        res.held_by_other = 1'b1;
                    else if (r.kind == KIND_LOCK)
                        res.granted = 1'b1;
                end
                else if (r.kind == KIND_LOCK)
                begin
                    if (held_locks.size() >= TABLE_DEPTH)
                        res.table_full = 1'b1;
                    else
                    begin
                        held_locks.push_back(e);
                        res.granted = 1'b1;
                    end
                end
            end
            KIND_UNLOCK:
            begin
                for (int i = 0; i < held_locks.size() && hit < 0; i++)
                begin
                    if (held_locks[i] == e)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    held_locks.delete(hit);
                    res.granted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.entries_used = RSP_COUNT_W'(held_locks.size());
        return res;
    endfunction

    task automatic send(logic [1:0] kind, logic [31:0] f, logic [7:0] s, logic [15:0] u);
        req_t r;
        r.kind = kind;
        r.file_key = f;
        r.sentence_index = s;
        r.user_key = u;
        pending_req.push_back(r);
        if (kind != KIND_UNUSED)
            items_queued++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
    endtask

    task automatic push_sequence();
        logic [31:0] f;
        logic [7:0] s;
        logic [15:0] u;
        logic [15:0] other;
        int n;
        f = file_pool[$urandom_range(0, 3)];
        s = sent_pool[$urandom_range(0, 5)];
        u = user_pool[$urandom_range(0, 2)];
        send(KIND_LOCK, f, s, u);
        n = $urandom_range(0, 4);
        repeat (n)
        begin
            other = user_pool[$urandom_range(0, 2)];
            case ($urandom_range(0, 2))
                0: send(KIND_CHECK, f, s, other);
                1: send(KIND_LOCK, f, s, other);
                default: send(KIND_LOCK, file_pool[$urandom_range(0, 3)],
                              sent_pool[$urandom_range(0, 5)], other);
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            send(KIND_UNLOCK, f, s, u);
    endtask

    task automatic push_noise();
        logic [1:0] k;
        logic [31:0] f;
        logic [7:0] s;
        logic [15:0] u;
        k = 2'($urandom_range(0, 3));
        f = $urandom;
        s = 8'($urandom);
        u = 16'($urandom);
        send(k, f, s, u);
        if (k == KIND_LOCK)
            send(KIND_UNLOCK, f, s, u);
    endtask

    task automatic push_broken();
        logic [31:0] f;
        logic [7:0] s;
        logic [15:0] u;
        f = file_pool[$urandom_range(0, 3)];
        s = sent_pool[$urandom_range(0, 5)];
        u = user_pool[$urandom_range(0, 2)];
        case ($urandom_range(0, 2))
            0: send(KIND_UNLOCK, f, s, u);
            1:
            begin
                send(KIND_LOCK, f, s, u);
                send(KIND_UNLOCK, f, s, u ^ 16'h0001);
            end
            default: send(KIND_CHECK, f, s, u);
        endcase
    endtask

    task automatic push_random(int count);
        int target;
        int pick;
        target = items_queued + count;
        while (items_queued < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                push_sequence();
            else if (pick < 9)
                push_noise();
            else
                push_broken();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp.push_back(lookup_lock(req));
                requests_done++;
                if (held_locks.size() > peak_entries)
                    peak_entries = held_locks.size();
                if (expected_rsp[$].granted && req.kind == KIND_LOCK)
                    grants++;
                if (expected_rsp[$].held_by_other)
                    refused_owner++;
                if (expected_rsp[$].table_full)
                    refused_full++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_req.size() > 0)
                begin
                    req_valid <= 1'b1;
                    req <= pending_req.pop_front();
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
            hold_left = 0;
            next_hold_at = 200;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_checked++;
                if (expected_rsp.size() == 0)
                begin
                    $error("Result item arrived with no request outstanding");
                    errors++;
                end
                else
                begin
                    rsp_t want;
                    want = expected_rsp.pop_front();
                    if (rsp.held_by_other !== want.held_by_other)
                    begin
                        $error("held_by_other mismatch: expected %0d, got %0d",
                               want.held_by_other, rsp.held_by_other);
                        errors++;
                    end
                    if (rsp.granted !== want.granted)
                    begin
                        $error("granted mismatch: expected %0d, got %0d",
                               want.granted, rsp.granted);
                        errors++;
                    end
                    if (rsp.table_full !== want.table_full)
                    begin
                        $error("table_full mismatch: expected %0d, got %0d",
                               want.table_full, rsp.table_full);
                        errors++;
                    end
                    if (rsp.entries_used !== want.entries_used)
                    begin
                        $error("entries_used mismatch: expected %0d, got %0d",
                               want.entries_used, rsp.entries_used);
                        errors++;
                    end
                end
            end
            if (hold_left == 0 && results_checked >= next_hold_at)
            begin
                hold_left = 300;
                next_hold_at += 400;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_rsp.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        foreach (file_pool[i])
            file_pool[i] = $urandom;
        foreach (sent_pool[i])
            sent_pool[i] = 8'($urandom);
        foreach (user_pool[i])
            user_pool[i] = 16'($urandom);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send(KIND_CHECK, 32'h0, 8'h00, 16'h0000);
        send(KIND_LOCK, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send(KIND_LOCK, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send(KIND_CHECK, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
        send(KIND_LOCK, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
        send(KIND_CHECK, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send(KIND_UNLOCK, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
        send(KIND_UNLOCK, 32'hFFFF_FFFE, 8'hFF, 16'hFFFF);
        send(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send(KIND_LOCK, 32'h0, 8'h00, 16'h0000);
        send(KIND_LOCK, 32'h0, 8'hFF, 16'h0001);
        send(KIND_LOCK, 32'hFFFF_FFFF, 8'h00, 16'h0002);
        send(KIND_UNLOCK, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send(KIND_CHECK, 32'h0, 8'h00, 16'hFFFF);
        send(KIND_UNLOCK, 32'h0, 8'hFF, 16'h0001);
        send(KIND_LOCK, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
        send(KIND_UNLOCK, 32'hFFFF_FFFF, 8'h00, 16'h0002);
        send(KIND_UNLOCK, 32'h0, 8'h00, 16'h0000);
        send(KIND_UNLOCK, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
        send(KIND_UNLOCK, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
        send(KIND_UNUSED, 32'h0, 8'h00, 16'h0000);
        wait_idle();

        // Fill the table to capacity, probe it while full, then empty it from the top.
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            fill_user[i] = 16'($urandom);
            send(KIND_LOCK, FILL_FILE + i, 8'(i), fill_user[i]);
        end
        send(KIND_LOCK, FILL_FILE - 1, 8'h00, 16'h1234);
        send(KIND_LOCK, FILL_FILE + 10, 8'd10, fill_user[10]);
        send(KIND_LOCK, FILL_FILE + 10, 8'd10, ~fill_user[10]);
        send(KIND_CHECK, FILL_FILE + 255, 8'd255, fill_user[255]);
        send(KIND_CHECK, FILL_FILE + 255, 8'd255, ~fill_user[255]);
        send(KIND_UNLOCK, FILL_FILE, 8'd0, fill_user[0]);
        send(KIND_LOCK, FILL_FILE - 1, 8'h00, 16'h1234);
        send(KIND_LOCK, FILL_FILE - 2, 8'h00, 16'h1234);
        send(KIND_UNLOCK, FILL_FILE - 1, 8'h00, 16'h1234);
        for (int i = TABLE_DEPTH - 1; i > 0; i--)
            send(KIND_UNLOCK, FILL_FILE + i, 8'(i), fill_user[i]);
        wait_idle();

        push_random(RANDOM_ITEMS / 2);
        wait_idle();
        push_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d requests: %0d locks granted, %0d owner refusals, %0d full refusals.",
                 requests_done, grants, refused_owner, refused_full);
        $display("Checked %0d results; the table peaked at %0d entries.",
                 results_checked, peak_entries);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/slt_pkg.sv
hw/rtl/slt_datapath.sv
hw/rtl/slt_ctrl.sv
hw/rtl/sentence_lock_table.sv
tb/sv/tb_top.sv
